FILE: src/sbp_pkg.sv
// Package with the word types, constants and field helpers of the signed shared-shift block packer.
`default_nettype none
package sbp_pkg;

	// Longest run of samples that one header can describe.
	localparam int unsigned MAX_RUN = 255;
	// Largest shift that a run header carries.
	localparam logic [4:0] SHIFT_CAP = 5'd16;
	// A magnitude with its top set bit above this position needs a shift.
	localparam int unsigned SHIFT_BASE = 14;

	// One input word: a signed sample and the frame end mark.
	typedef struct packed {
		logic signed [31:0] sample;
		logic               last_sample;
	} in_word_t;

	// One output word: a halfword write into the frame buffer.
	typedef struct packed {
		logic [11:0] word_index;
		logic [15:0] word_data;
		logic        is_header;
		logic        frame_done;
		logic [13:0] byte_count;
	} out_word_t;

	// Sign, saturated magnitude and shift of one sample.
	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
		logic [4:0]  shift;
	} sample_class_t;

	// Header halfword: count in the high byte, sign and capped shift in the low byte.
	function automatic logic [15:0] header_word(input logic [7:0] count, input logic neg,
		input logic [4:0] shift);
		logic [4:0] sh;
		sh = (shift > SHIFT_CAP) ? SHIFT_CAP : shift;
		return {count, neg, 2'b00, sh};
	endfunction

endpackage
`default_nettype wire

FILE: src/sbp_classify.sv
// Sign, saturated magnitude and shift of the sample held in the input register.
`default_nettype none
module sbp_classify (
	input  wire sbp_pkg::in_word_t      item,
	output sbp_pkg::sample_class_t      cls
);
	import sbp_pkg::*;

	logic        neg;
	logic [31:0] mag_full;
	logic [4:0]  shift;

	// The most negative sample saturates to the largest positive magnitude.
	always_comb begin
		neg = item.sample[31];
		if (!neg) begin
			mag_full = item.sample;
		end else if (item.sample == 32'sh8000_0000) begin
			mag_full = 32'h7FFF_FFFF;
		end else begin
			mag_full = 32'(-item.sample);
		end
	end

	// Shift is the top set bit position less 14, or zero for small values and zero.
	always_comb begin
		shift = 5'd0;
		for (int p = SHIFT_BASE + 1; p < 31; p++) begin
			if (mag_full[p]) begin
				shift = 5'(p - SHIFT_BASE);
			end
		end
	end

	assign cls.neg   = neg;
	assign cls.mag   = mag_full[30:0];
	assign cls.shift = shift;

endmodule
`default_nettype wire

FILE: src/sbp_run_ctrl.sv
// Run state, write sequencer and output register of the block packer.
`default_nettype none
module sbp_run_ctrl #(
	parameter int unsigned MAX_RUN = sbp_pkg::MAX_RUN
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         item_valid,
	input  wire sbp_pkg::in_word_t      item,
	input  wire sbp_pkg::sample_class_t cls,
	output logic                        item_done,
	output logic                        result_valid,
	input  wire                         result_stall,
	output sbp_pkg::out_word_t          result_word
);
	import sbp_pkg::*;

	typedef enum logic [1:0] {
		SEL_CLOSE,
		SEL_VALUE,
		SEL_FINAL
	} sel_t;

	sel_t        sel_q;
	sel_t        cur;
	logic        open_q;
	logic        neg_q;
	logic [4:0]  gs_q;
	logic [7:0]  len_q;
	logic [11:0] hs_q;
	logic [12:0] ns_q;
	logic        result_valid_q;
	out_word_t   result_word_q;

	logic [4:0]  diff;
	logic        join_run;
	logic        close_run;
	logic        n_neg;
	logic [4:0]  n_gs;
	logic [4:0]  n_cap;
	logic [7:0]  n_len;
	logic [11:0] n_hs;
	logic [12:0] ns1;
	logic [12:0] ns2;
	logic        load;
	logic        ends_item;
	out_word_t   word_sel;

	// Decide whether the sample joins the open run and what the run looks like after it.
	always_comb begin
		diff      = (cls.shift > gs_q) ? cls.shift - gs_q : gs_q - cls.shift;
		join_run  = open_q && (neg_q == cls.neg) && (diff <= 5'd1) &&
			(len_q < 8'(MAX_RUN));
		close_run = open_q && !join_run;
		n_neg     = join_run ? neg_q : cls.neg;
		n_gs      = join_run ? gs_q : cls.shift;
		n_cap     = (n_gs > SHIFT_CAP) ? SHIFT_CAP : n_gs;
		n_hs      = join_run ? hs_q : ns_q[11:0];
		ns1       = join_run ? ns_q : ns_q + 13'd1;
		ns2       = ns1 + 13'd1;
		n_len     = (join_run ? len_q : 8'd0) + 8'd1;
	end

	// Pick the write for this cycle: closing header, sample value, or final header.
	always_comb begin
		cur = (sel_q == SEL_CLOSE && !close_run) ? SEL_VALUE : sel_q;
		word_sel = '0;
		case (cur)
			SEL_CLOSE: begin
				word_sel.word_index = hs_q;
				word_sel.word_data  = header_word(len_q, neg_q, gs_q);
				word_sel.is_header  = 1'b1;
			end
			SEL_VALUE: begin
				word_sel.word_index = ns1[11:0];
				word_sel.word_data  = 16'(cls.mag >> n_cap);
			end
			SEL_FINAL: begin
				word_sel.word_index = n_hs;
				word_sel.word_data  = header_word(n_len, n_neg, n_gs);
				word_sel.is_header  = 1'b1;
				word_sel.frame_done = 1'b1;
				word_sel.byte_count = {ns2, 1'b0};
			end
			default: begin
				word_sel = '0;
			end
		endcase
	end

	assign load      = !result_valid_q || !result_stall;
	assign ends_item = (cur == SEL_FINAL) || (cur == SEL_VALUE && !item.last_sample);
	assign item_done = item_valid && load && ends_item;

	// Run state and sequencer advance only when a write enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q          <= SEL_CLOSE;
			open_q         <= 1'b0;
			neg_q          <= 1'b0;
			gs_q           <= 5'd0;
			len_q          <= 8'd0;
			hs_q           <= 12'd0;
			ns_q           <= 13'd0;
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= item_valid;
			if (item_valid) begin
				result_word_q <= word_sel;
				case (cur)
					SEL_CLOSE: begin
						sel_q <= SEL_VALUE;
					end
					SEL_VALUE: begin
						if (item.last_sample) begin
							sel_q <= SEL_FINAL;
						end else begin
							sel_q  <= SEL_CLOSE;
							open_q <= 1'b1;
							neg_q  <= n_neg;
							gs_q   <= n_gs;
							len_q  <= n_len;
							hs_q   <= n_hs;
							ns_q   <= ns2;
						end
					end
					SEL_FINAL: begin
						// The frame is over: the next sample starts at offset zero.
						sel_q  <= SEL_CLOSE;
						open_q <= 1'b0;
						neg_q  <= 1'b0;
						gs_q   <= 5'd0;
						len_q  <= 8'd0;
						hs_q   <= 12'd0;
						ns_q   <= 13'd0;
					end
					default: begin
						sel_q <= SEL_CLOSE;
					end
				endcase
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_word_q;

endmodule
`default_nettype wire

FILE: src/signed_shared_shift_block_packer_top.sv
// Top level of the signed shared-shift block packer: input register, classifier and run control.
// Path: a sample passes the input register and the classifier, then its writes enter the output register.
// Throughput: one word per cycle while result_stall is low; a sample writes its value, after a closing
// header when it closes a run, and before the final header when it ends the frame.
// Reset: arst_n clears the input and output valids, the run state and the write offset.
`default_nettype none
module signed_shared_shift_block_packer_top #(
	parameter int unsigned MAX_RUN = sbp_pkg::MAX_RUN
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    sample_valid,
	output logic                   sample_stall,
	input  wire sbp_pkg::in_word_t sample_word,
	output logic                   result_valid,
	input  wire                    result_stall,
	output sbp_pkg::out_word_t     result_word
);
	import sbp_pkg::*;

	logic          valid_s1;
	in_word_t      word_s1;
	sample_class_t cls;
	logic          item_done;

	// The input register takes a new word in the cycle its current one finishes.
	assign sample_stall = valid_s1 && !item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			word_s1 <= sample_word;
		end
	end

	sbp_classify u_classify (
		.item (word_s1),
		.cls  (cls)
	);

	sbp_run_ctrl #(
		.MAX_RUN (MAX_RUN)
	) u_run_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.item         (word_s1),
		.cls          (cls),
		.item_done    (item_done),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

	// A finished sample always leaves a word in the output register.
	a_done_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_done |=> result_valid)
		else $error("sample finished without a write");

	// The frame end is only ever flagged on a header write.
	a_done_is_header: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_word.frame_done) |-> result_word.is_header)
		else $error("frame end on a value write");

	// The byte count is zero on every write but the last of a frame.
	a_bytes_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_word.frame_done) |-> (result_word.byte_count == 14'd0))
		else $error("byte count outside frame end");

	// Header low bytes carry a shift of at most 16 with the unused bits clear.
	a_header_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_word.is_header) |->
		(result_word.word_data[6:5] == 2'b00 &&
		(result_word.word_data[4] == 1'b0 || result_word.word_data[3:0] == 4'd0)))
		else $error("malformed run header");

endmodule
`default_nettype wire
